/* rtl/ple_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine: request and
// response payloads, command codes and the front-to-back work record.
// ----------------------------------------------------------------------------
package ple_pkg;

   // Element count width; the count runs from 0 to 64 inclusive
   localparam int CNT_W = 7;

   // Command codes carried in a request
   localparam logic [2:0] CMD_LENGTH = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_QUERY  = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_DUMP   = 3'd4;

   // Value returned for a missing element or an empty list
   localparam logic signed [31:0] MISSING_VALUE = -32'sd1;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [6:0]         position;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               is_last;
   } rsp_type;

   // Decoded operation handed from front to back
   typedef enum logic [2:0] {
      OP_LEN,
      OP_INS,
      OP_QRY,
      OP_REM,
      OP_DUMP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [6:0]         position;
      logic signed [31:0] item_value;
   } work_type;

   // Head of the work queue as seen by the back end
   typedef struct packed {
      logic     valid;
      work_type work;
   } queue_out_type;

   // Back-end status
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             busy;
   } stat_type;

endpackage

/* rtl/positional_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values with length, insert, query,
// remove and dump commands.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on req_valid/req_stall/req_data; a request is taken on a
//    clock edge with req_valid high and req_stall low. Responses leave on
//    rsp_valid/rsp_stall/rsp_data in command order.
//  - A two-entry queue sits between the decoder and the executor, so the
//    request side keeps accepting while the executor works or waits.
//  - Each element move on insert or remove is one read followed by one
//    write, as set by the single-write, registered-read element memory.
//  - Ignored inserts and removes (full list, bad position) produce no
//    response; unused codes are dropped by the decoder and never reach the
//    executor. Query and length give one response; dump gives one per
//    element, with is_last on the final one (one missing-value response for an empty list).
//  - Reset empties the list and clears the queue and response register.
//  - While rsp_stall is high a valid response register holds its value and
//    only commands that respond wait; requests fill the queue until full.
// ----------------------------------------------------------------------------
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   queue_out_type q_out;
   logic          q_pop;
   stat_type      stat;

   ple_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_out     (q_out),
      .q_pop     (q_pop)
   );

   ple_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_out     (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .stat      (stat)
   );

   // List never grows past capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // Reset leaves an empty list and no pending response
   a_reset_clear: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && stat.count == '0))
      else $error("state not cleared by reset");

   // A non-final dump response means the executor is still in the run
   a_dump_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.is_last) |-> stat.busy)
      else $error("non-final response with executor idle");

   // Executor only pops a queued command
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_out.valid)
      else $error("pop from empty work queue");

endmodule

/* rtl/ple_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_front
// Request front end: decodes the command of each request, drops unused
// codes and queues the rest in a two-entry work queue for the back end.
// ----------------------------------------------------------------------------
module ple_front
   import ple_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output queue_out_type q_out,
   input  logic          q_pop
);

   work_type   ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   work_type   dec;
   logic       known;
   logic       push;

   // Command decode
   always_comb begin
      dec.position   = req_data.position;
      dec.item_value = req_data.item_value;
      dec.op         = OP_LEN;
      known          = 1'b1;
      case (req_data.cmd)
         CMD_LENGTH: dec.op = OP_LEN;
         CMD_INSERT: dec.op = OP_INS;
         CMD_QUERY:  dec.op = OP_QRY;
         CMD_REMOVE: dec.op = OP_REM;
         CMD_DUMP:   dec.op = OP_DUMP;
         default:    known  = 1'b0;
      endcase
   end

   // Queue pointers and fill level
   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall && known;

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= dec;
      end
   end

   assign q_out.valid = (fill_ff != 2'd0);
   assign q_out.work  = ent_ff[rd_ptr_ff];

endmodule

/* rtl/ple_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_back
// Execution back end: holds the list in a single-port-write, registered-read
// memory, shifts elements one at a time (a read, then a write) on insert and
// remove, and drives the response register.
// ----------------------------------------------------------------------------
module ple_back
   import ple_pkg::*;
#(
   parameter int CAPACITY = 64
)
(
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type q_out,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   output stat_type      stat
);

   localparam int               AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_REM_RD,
      ST_REM_WR,
      ST_RD,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic signed [31:0] val_ff, val_in;
   logic               single_ff, single_in;
   logic               miss_ff, miss_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic signed [31:0] mem [CAPACITY];
   logic signed [31:0] rd_ff;
   logic [CNT_W-1:0]   rd_addr;
   logic               we;
   logic [CNT_W-1:0]   wa;
   logic signed [31:0] wd;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer: command dispatch, shift loops and response loading
   always_comb begin
      logic last;
      last         = 1'b0;
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      single_in    = single_ff;
      miss_in      = miss_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr      = cur_ff;
      we           = 1'b0;
      wa           = cur_ff;
      wd           = rd_ff;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            miss_in = 1'b0;
            if (q_out.valid) begin
               case (q_out.work.op)
                  OP_LEN: begin
                     if (slot_free) begin
                        q_pop               = 1'b1;
                        rsp_valid_in        = 1'b1;
                        rsp_in.result_value = $signed({{(32-CNT_W){1'b0}}, count_ff});
                        rsp_in.is_last      = 1'b1;
                     end
                  end
                  OP_INS: begin
                     q_pop = 1'b1;
                     if (count_ff < CAP_C && q_out.work.position <= count_ff) begin
                        cur_in   = count_ff;
                        pos_in   = q_out.work.position;
                        val_in   = q_out.work.item_value;
                        state_in = ST_INS_RD;
                     end
                  end
                  OP_QRY: begin
                     q_pop     = 1'b1;
                     single_in = 1'b1;
                     if (q_out.work.position >= count_ff) begin
                        miss_in  = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        cur_in   = q_out.work.position;
                        state_in = ST_RD;
                     end
                  end
                  OP_REM: begin
                     q_pop = 1'b1;
                     if (q_out.work.position < count_ff) begin
                        cur_in   = q_out.work.position;
                        state_in = ST_REM_RD;
                     end
                  end
                  OP_DUMP: begin
                     q_pop     = 1'b1;
                     single_in = 1'b0;
                     if (count_ff == '0) begin
                        miss_in  = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        cur_in   = '0;
                        state_in = ST_RD;
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         // Insert: move entries up from the tail, then place the value
         ST_INS_RD: begin
            if (cur_ff > pos_ff) begin
               rd_addr  = cur_ff - 1'b1;
               state_in = ST_INS_WR;
            end else begin
               we       = 1'b1;
               wa       = pos_ff;
               wd       = val_ff;
               count_in = count_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_INS_WR: begin
            we       = 1'b1;
            cur_in   = cur_ff - 1'b1;
            state_in = ST_INS_RD;
         end
         // Remove: move entries down over the gap
         ST_REM_RD: begin
            if (cur_ff + 1'b1 < count_ff) begin
               rd_addr  = cur_ff + 1'b1;
               state_in = ST_REM_WR;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_REM_WR: begin
            we       = 1'b1;
            cur_in   = cur_ff + 1'b1;
            state_in = ST_REM_RD;
         end
         ST_RD: state_in = ST_OUT;
         // Query and dump output; read address held so rd_ff stays put
         ST_OUT: begin
            if (slot_free) begin
               last                = miss_ff || single_ff || (cur_ff + 1'b1 == count_ff);
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = miss_ff ? MISSING_VALUE : rd_ff;
               rsp_in.is_last      = last;
               if (last) begin
                  state_in = ST_IDLE;
               end else begin
                  cur_in   = cur_ff + 1'b1;
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         miss_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         miss_ff      <= miss_in;
      end
   end

   // Payload and cursor registers
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      single_ff <= single_in;
      rsp_ff    <= rsp_in;
   end

   // Element memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa[AW-1:0]] <= wd;
      end
      rd_ff <= mem[rd_addr[AW-1:0]];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign stat.count = count_ff;
   assign stat.busy  = (state_ff != ST_IDLE);

endmodule
